/* rtl/wt_pkg.sv */
// Shared constants and codes for the wavetable oscillator.
// No dependencies; imported by wt_ifs, wt_smul and the top level.
`default_nettype none

package wt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 8;
    localparam int TLEN_W     = 9;
    localparam int RLEN_W     = 16;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CHAN_W-1:0] CH_STEREO = 2'd2;

    localparam logic [TLEN_W-1:0] TLEN_RESET = 9'd100;
    localparam logic [RLEN_W-1:0] RLEN_RESET = 16'd100;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd1;

endpackage

`default_nettype wire

/* rtl/wt_ifs.sv */
// Valid/ready channel interfaces: command items, result items, register writes.
// Depends on wt_pkg for field widths.
`default_nettype none

interface wt_cmd_if
    import wt_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [INDEX_W-1:0]         load_index;
    logic signed [SAMPLE_W-1:0] load_value;

    modport source (output valid, op, load_index, load_value, input ready);
    modport sink   (input valid, op, load_index, load_value, output ready);
endinterface

interface wt_res_if
    import wt_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       last;

    modport source (output valid, sample, channel, last, input ready);
    modport sink   (input valid, sample, channel, last, output ready);
endinterface

interface wt_cfg_if
    import wt_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/wt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/wt_smul.sv */
// Bit-serial dot product a*wa + b*wb, one weight bit per cycle, MSB first.
// Depends on wt_pkg.
`default_nettype none

module wt_smul
    import wt_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [SAMPLE_W-1:0] coef_a,
    input  wire logic signed [SAMPLE_W-1:0] coef_b,
    input  wire logic [RLEN_W-1:0]          weight_a,
    input  wire logic [RLEN_W-1:0]          weight_b,
    output logic                            busy,
    output logic signed [PROD_W-1:0]        product
);

    localparam int CNT_W = $clog2(RLEN_W + 1);

    logic signed [PROD_W-1:0]   acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] a_reg, b_reg;
    logic [RLEN_W-1:0]          wa_reg, wb_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [PROD_W-1:0]   term_a, term_b;

    always_comb
    begin
        term_a   = wa_reg[RLEN_W-1] ? PROD_W'(a_reg) : '0;
        term_b   = wb_reg[RLEN_W-1] ? PROD_W'(b_reg) : '0;
        acc_next = (acc_reg <<< 1) + term_a + term_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(RLEN_W);
            acc_reg <= '0;
            a_reg   <= coef_a;
            b_reg   <= coef_b;
            wa_reg  <= weight_a;
            wb_reg  <= weight_b;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            acc_reg <= acc_next;
            wa_reg  <= {wa_reg[RLEN_W-2:0], 1'b0};
            wb_reg  <= {wb_reg[RLEN_W-2:0], 1'b0};
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

endmodule

`default_nettype wire

/* rtl/wt_sdiv.sv */
// Restoring divider, one quotient bit per cycle; dividend = {rem_init, low_bits}.
// rem_init must be below divisor. No dependencies.
`default_nettype none

module wt_sdiv #(
    parameter int QW = 16,
    parameter int DW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] rem_init,
    input  wire logic [QW-1:0] low_bits,
    input  wire logic [DW-1:0] divisor,
    output logic               busy,
    output logic [QW-1:0]      quotient,
    output logic [DW-1:0]      remainder
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    q_reg;
    logic [DW-1:0]    div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW:0]      shifted, trial;
    logic             q_bit;

    always_comb
    begin
        shifted = {rem_reg, q_reg[QW-1]};
        trial   = shifted - {1'b0, div_reg};
        q_bit   = !trial[DW];
        rem_next = q_bit ? trial[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(QW);
            rem_reg <= rem_init;
            q_reg   <= low_bits;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QW-2:0], q_bit};
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/wavetable_oscillator.sv */
// Wavetable oscillator top level: table RAM, serial MAC, serial dividers, sequencer.
// Depends on wt_pkg, wt_ifs, wt_ram, wt_smul, wt_sdiv.
//
//  Channel  Dir  Payload                      Accepted when
//  cmd      in   op, load_index, load_value   cmd.valid && cmd.ready
//  result   out  sample, channel, last        result.valid && result.ready
//  cfg      in   index, data                  cfg.valid && cfg.ready (always ready)
//
// A load is written to the table when it is accepted. A tick's result is formed by two
// table reads, the 16-step bit-serial multiply, forming the dividend, the 16-step
// rounding divide by 2*ring_len and loading the result register, in that order. The
// next item is taken in the cycle after the result load. Position update divides
// run alongside. Reset is asynchronous and clears control state, configuration and
// position registers; table contents are undefined until loaded. A held result does
// not block loads; a tick waits at its end until the result register is free.
`default_nettype none

module wavetable_oscillator
    import wt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input wire logic  clk,
    input wire logic  rst_n,
    wt_cmd_if.sink    cmd,
    wt_res_if.source  result,
    wt_cfg_if.sink    cfg
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int LEN_CAP = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_B,
        S_START,
        S_MUL,
        S_NORM,
        S_DIV,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [TLEN_W-1:0]          tlen_reg;
    logic [RLEN_W-1:0]          rlen_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic [INDEX_W-1:0]         k_reg;
    logic [RLEN_W-1:0]          r_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_channel_reg;
    logic                       out_last_reg;
    logic                       pend_right_reg;

    logic [TLEN_W-1:0]          tl;
    logic [RLEN_W-1:0]          rl;
    logic [INDEX_W-1:0]         kn;
    logic [INDEX_W-1:0]         rd_index;
    logic [AW+INDEX_W-1:0]      rd_wide, wr_wide;
    logic [AW-1:0]              raddr, waddr;
    logic                       we;
    logic [SAMPLE_W-1:0]        rdata;
    logic                       cmd_fire, res_fire, cfg_fire;
    logic                       stereo;

    logic                       mul_start, mul_busy;
    logic signed [PROD_W-1:0]   product;
    logic [PROD_W:0]            n_full;

    logic                       pos_start, pos_busy;
    logic [RLEN_W:0]            pos_sum;
    logic [INDEX_W-1:0]         pos_q;
    logic [RLEN_W-1:0]          pos_rem;

    logic                       wrap_busy;
    logic [TLEN_W-1:0]          wrap_sum;
    logic [TLEN_W-1:0]          wrap_rem;

    logic                       sdiv_start, sdiv_busy;
    logic [SAMPLE_W-1:0]        sdiv_q;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign res_fire = result.valid && result.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign stereo   = (chan_reg == CH_STEREO);

    always_comb
    begin
        if (tlen_reg < TLEN_W'(2))
            tl = TLEN_W'(2);
        else if (tlen_reg > TLEN_W'(LEN_CAP))
            tl = TLEN_W'(LEN_CAP);
        else
            tl = tlen_reg;
        rl = (rlen_reg < RLEN_W'(2)) ? RLEN_W'(2) : rlen_reg;
        kn = ({1'b0, k_reg} + 9'd1 >= tl) ? '0 : k_reg + 1'b1;
    end

    // table RAM
    assign rd_index = (state_reg == S_READ_B) ? kn : k_reg;
    assign rd_wide  = {{AW{1'b0}}, rd_index};
    assign raddr    = rd_wide[AW-1:0];
    assign wr_wide  = {{AW{1'b0}}, cmd.load_index};
    assign waddr    = wr_wide[AW-1:0];
    assign we       = cmd_fire && (cmd.op == OP_LOAD)
                      && ({24'd0, cmd.load_index} < 32'(TABLE_DEPTH));

    wt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.load_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // num = a*(rl - r) + b*r
    assign mul_start = (state_reg == S_START);

    wt_smul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .coef_a   (a_reg),
        .coef_b   ($signed(rdata)),
        .weight_a (rl - r_reg),
        .weight_b (r_reg),
        .busy     (mul_busy),
        .product  (product)
    );

    // position advance: (r + tl) / rl, then (k + q) mod tl
    assign pos_start = mul_start;
    assign pos_sum   = {1'b0, r_reg} + {8'd0, tl};

    wt_sdiv #(
        .QW (INDEX_W),
        .DW (RLEN_W)
    ) u_pos_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pos_start),
        .rem_init  ({7'd0, pos_sum[RLEN_W:INDEX_W]}),
        .low_bits  (pos_sum[INDEX_W-1:0]),
        .divisor   (rl),
        .busy      (pos_busy),
        .quotient  (pos_q),
        .remainder (pos_rem)
    );

    assign sdiv_start = (state_reg == S_NORM);
    assign wrap_sum   = {1'b0, k_reg} + {1'b0, pos_q};

    wt_sdiv #(
        .QW (INDEX_W),
        .DW (TLEN_W)
    ) u_wrap_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sdiv_start),
        .rem_init  ({8'd0, wrap_sum[INDEX_W]}),
        .low_bits  (wrap_sum[INDEX_W-1:0]),
        .divisor   (tl),
        .busy      (wrap_busy),
        .quotient  (),
        .remainder (wrap_rem)
    );

    // floor((2*num + rl) / (2*rl)) offset by 32768 to keep the dividend positive
    assign n_full = {product, 1'b0} + {3'd0, rl, rl};

    wt_sdiv #(
        .QW (SAMPLE_W),
        .DW (RLEN_W + 1)
    ) u_sample_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sdiv_start),
        .rem_init  (n_full[32:16]),
        .low_bits  (n_full[15:0]),
        .divisor   ({rl, 1'b0}),
        .busy      (sdiv_busy),
        .quotient  (sdiv_q),
        .remainder ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tlen_reg        <= TLEN_RESET;
            rlen_reg        <= RLEN_RESET;
            chan_reg        <= CHAN_RESET;
            k_reg           <= '0;
            r_reg           <= '0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= 1'b0;
            out_last_reg    <= 1'b0;
            pend_right_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    CFG_TABLE_LEN:
                    begin
                        tlen_reg <= cfg.data[TLEN_W-1:0];
                        k_reg    <= '0;
                        r_reg    <= '0;
                    end
                    CFG_RING_LEN:
                    begin
                        rlen_reg <= cfg.data[RLEN_W-1:0];
                        k_reg    <= '0;
                        r_reg    <= '0;
                    end
                    CFG_CHANNELS:
                    begin
                        chan_reg <= cfg.data[CHAN_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (res_fire)
            begin
                if (pend_right_reg)
                begin
                    out_channel_reg <= 1'b1;
                    out_last_reg    <= 1'b1;
                    pend_right_reg  <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire && (cmd.op == OP_TICK))
                        state_reg <= S_READ_B;
                end
                S_READ_B:
                begin
                    a_reg     <= $signed(rdata);
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (!mul_busy && !pos_busy)
                        state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!sdiv_busy && !wrap_busy)
                    begin
                        k_reg     <= wrap_rem[INDEX_W-1:0];
                        r_reg     <= pos_rem;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_sample_reg  <= $signed(sdiv_q ^ 16'h8000);
                        out_channel_reg <= 1'b0;
                        out_last_reg    <= !stereo;
                        pend_right_reg  <= stereo;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.sample  = out_sample_reg;
    assign result.channel = out_channel_reg;
    assign result.last    = out_last_reg;

endmodule

`default_nettype wire
